// ===== src/tpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle plane clipper package
// Shared unit opcodes, register indexes, the vertex emission descriptor and the divider status.
// ----------------------------------------------------------------------------
package tpc_pkg;

    localparam int NUM_ATTR = 7;

    typedef logic [1:0] fxu_op_t;
    localparam fxu_op_t FXU_ADD = 2'd0;
    localparam fxu_op_t FXU_SUB = 2'd1;
    localparam fxu_op_t FXU_MAC = 2'd2;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_NORMAL_X = 3'd0;
    localparam reg_idx_t REG_NORMAL_Y = 3'd1;
    localparam reg_idx_t REG_NORMAL_Z = 3'd2;
    localparam reg_idx_t REG_POINT_X  = 3'd3;
    localparam reg_idx_t REG_POINT_Y  = 3'd4;
    localparam reg_idx_t REG_POINT_Z  = 3'd5;

    // one output vertex: zero fill, copy of a source corner, or an edge cut
    typedef struct packed {
        logic       zero;
        logic       cut;
        logic       sel;
        logic [1:0] src;
        logic       tri_sel;
        logic [1:0] corner;
        logic       last;
    } emit_desc_t;

    typedef struct packed {
        logic busy;
    } div_status_t;

endpackage

// ===== src/tpc_fxu.sv =====
// ----------------------------------------------------------------------------
// Shared fixed point unit
// Saturating add/subtract, rounded product accumulate and a 32x32 multiplier.
// ----------------------------------------------------------------------------
module tpc_fxu import tpc_pkg::*; #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  fxu_op_t                op,
    input  logic signed [W-1:0]    a,
    input  logic signed [W-1:0]    b,
    input  logic signed [31:0]     ma,
    input  logic signed [31:0]     mb,
    input  logic signed [63:0]     p,
    output logic signed [W-1:0]    res,
    output logic signed [63:0]     prod
);

    localparam logic signed [W:0] HI = {2'b00, {(W-1){1'b1}}};
    localparam logic signed [W:0] LO = {2'b11, {(W-1){1'b0}}};
    localparam logic signed [63:0] HI64 = 64'(HI);
    localparam logic signed [63:0] LO64 = 64'(LO);
    localparam logic signed [63:0] HALF = 64'sd1 <<< (F-1);

    logic signed [63:0]  rnd;
    logic signed [W-1:0] rnd_sat;
    logic signed [W-1:0] opb;
    logic signed [W:0]   sum;

    always_comb begin
        rnd = (p + HALF) >>> F;
        if (rnd > HI64) begin
            rnd_sat = HI[W-1:0];
        end else if (rnd < LO64) begin
            rnd_sat = LO[W-1:0];
        end else begin
            rnd_sat = rnd[W-1:0];
        end
        opb = (op == FXU_MAC) ? rnd_sat : b;
        if (op == FXU_SUB) begin
            sum = {a[W-1], a} - {opb[W-1], opb};
        end else begin
            sum = {a[W-1], a} + {opb[W-1], opb};
        end
        if (sum > HI) begin
            res = HI[W-1:0];
        end else if (sum < LO) begin
            res = LO[W-1:0];
        end else begin
            res = sum[W-1:0];
        end
        prod = ma * mb;
    end

endmodule

// ===== src/tpc_div.sv =====
// ----------------------------------------------------------------------------
// Edge parameter divider
// Restoring divider, one quotient bit per cycle: q = (num << F) / den,
// for 0 <= num <= den.
// ----------------------------------------------------------------------------
module tpc_div import tpc_pkg::*; #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [W-1:0]  num,
    input  logic [W-1:0]  den,
    output div_status_t   status,
    output logic [F:0]    q
);

    localparam int CW = $clog2(F + 2);

    logic [W:0]    r_reg, r_next, rs;
    logic [W-1:0]  den_reg, den_next;
    logic [F:0]    q_reg, q_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          first_reg, first_next;
    logic          ge;

    always_comb begin
        rs         = first_reg ? r_reg : {r_reg[W-1:0], 1'b0};
        ge         = rs >= {1'b0, den_reg};
        r_next     = r_reg;
        den_next   = den_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        first_next = first_reg;
        if (start) begin
            r_next     = {1'b0, num};
            den_next   = den;
            q_next     = '0;
            cnt_next   = CW'(F + 1);
            busy_next  = 1'b1;
            first_next = 1'b1;
        end else if (busy_reg) begin
            r_next     = ge ? rs - {1'b0, den_reg} : rs;
            q_next     = {q_reg[F-1:0], ge};
            first_next = 1'b0;
            cnt_next   = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            first_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            busy_reg  <= busy_next;
            first_reg <= first_next;
            cnt_reg   <= cnt_next;
        end
        r_reg   <= r_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign status.busy = busy_reg;
    assign q           = q_reg;

endmodule

// ===== src/triangle_plane_clipper.sv =====
// ----------------------------------------------------------------------------
// Triangle plane clipper
// Corners 0 and 1 are stored as they arrive; corner 2 starts clipping
// against the plane and the block emits 1, 3 or 6 vertex transactions.
// ----------------------------------------------------------------------------
// Flow: a slot 0 or 1 vertex is stored while s_ready is high. A slot 2 vertex
// keeps s_ready low, also through output stalls on m_ready, until its last
// output vertex is loaded. One shared adder/multiplier forms the three plane
// distances, the edge denominators for the divider after the classification
// finds a straddle, and each cut vertex: seven attributes, four steps each.
module triangle_plane_clipper import tpc_pkg::*; #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic signed [31:0] s_tex_u,
    input  logic signed [31:0] s_tex_v,
    input  logic signed [31:0] s_tex_w,
    input  logic signed [31:0] s_light,
    input  logic [15:0]        s_tri_tag,
    input  logic [1:0]         s_vertex_slot,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic signed [31:0] m_out_z,
    output logic signed [31:0] m_out_u,
    output logic signed [31:0] m_out_v,
    output logic signed [31:0] m_out_w,
    output logic signed [31:0] m_out_light,
    output logic [15:0]        m_out_tag,
    output logic               m_out_tri,
    output logic [1:0]         m_out_corner,
    output logic [1:0]         m_out_count,
    output logic               m_out_last
);

    localparam int W = (WORD_BITS < 32) ? WORD_BITS : 32;
    localparam int F = FRAC_BITS;
    localparam logic signed [W:0]  HI = {2'b00, {(W-1){1'b1}}};
    localparam logic signed [W:0]  LO = {2'b11, {(W-1){1'b0}}};
    localparam logic signed [31:0] HI32 = 32'(HI);
    localparam logic signed [31:0] LO32 = 32'(LO);
    localparam logic signed [W-1:0] ONE_LSB = W'(1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_D_SUB = 4'd1;
    localparam logic [3:0] ST_D_MUL = 4'd2;
    localparam logic [3:0] ST_D_ACC = 4'd3;
    localparam logic [3:0] ST_CLASS = 4'd4;
    localparam logic [3:0] ST_V_DEN = 4'd5;
    localparam logic [3:0] ST_V_RUN = 4'd6;
    localparam logic [3:0] ST_PREP  = 4'd7;
    localparam logic [3:0] ST_C_RD  = 4'd8;
    localparam logic [3:0] ST_C_SUB = 4'd9;
    localparam logic [3:0] ST_C_MUL = 4'd10;
    localparam logic [3:0] ST_C_ACC = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;

    function automatic logic signed [W-1:0] sat_word(input logic [31:0] raw);
        logic signed [31:0] s;
        s = raw;
        if (s > HI32) begin
            return HI[W-1:0];
        end else if (s < LO32) begin
            return LO[W-1:0];
        end
        return s[W-1:0];
    endfunction

    logic [3:0]           state_reg, state_next;
    logic signed [W-1:0]  vtx_reg [3][NUM_ATTR];
    logic signed [W-1:0]  nrm_reg [3];
    logic signed [W-1:0]  pnt_reg [3];
    logic signed [W-1:0]  dist_reg [3];
    logic signed [W-1:0]  wrk_reg [NUM_ATTR];
    logic [15:0]          held_tag_reg;
    logic [1:0]           vi_reg;
    logic [1:0]           k_reg;
    logic [2:0]           j_reg;
    logic [2:0]           e_reg;
    logic                 sel_reg;
    logic signed [W-1:0]  acc_reg;
    logic signed [W-1:0]  tmp_reg;
    logic signed [W-1:0]  a_reg;
    logic signed [63:0]   prod_reg;
    logic [F:0]           t_reg [2];
    logic                 m_valid_reg;

    fxu_op_t              fx_op;
    logic signed [W-1:0]  fx_a, fx_b, fx_res;
    logic signed [31:0]   fx_ma, fx_mb;
    logic signed [63:0]   fx_prod;
    logic signed [W-1:0]  den_val;
    logic                 div_start;
    div_status_t          div_st;
    logic [F:0]           div_q;

    logic [2:0]           ins;
    logic [1:0]           ni;
    logic [1:0]           i0, i1, o0, o1;
    logic [1:0]           cut_in [2];
    logic [1:0]           cut_out [2];
    logic [1:0]           ci, co;
    logic [1:0]           tri_count;
    emit_desc_t           desc;
    logic                 s_fire, out_load;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // classification of the three corners
    always_comb begin
        ins = {~dist_reg[2][W-1], ~dist_reg[1][W-1], ~dist_reg[0][W-1]};
        ni  = '0;
        i0  = '0;
        i1  = '0;
        o0  = '0;
        o1  = '0;
        for (int i = 0; i < 3; i++) begin
            if (ins[i]) begin
                if (ni == 2'd0) begin
                    i0 = 2'(i);
                end else begin
                    i1 = 2'(i);
                end
                ni = ni + 2'd1;
            end else if ((i - int'(ni)) == 0) begin
                o0 = 2'(i);
            end else begin
                o1 = 2'(i);
            end
        end
        if (ins == 3'b111) begin
            ni = 2'd3;
        end
        tri_count  = (ni == 2'd3) ? 2'd1 : ni;
        cut_in[0]  = i0;
        cut_out[0] = o0;
        cut_in[1]  = (ni == 2'd1) ? i0 : i1;
        cut_out[1] = (ni == 2'd1) ? o1 : o0;
        ci         = cut_in[sel_reg];
        co         = cut_out[sel_reg];
    end

    // emission order of the output vertices
    always_comb begin
        desc = '0;
        case (ni)
            2'd0: begin
                desc.zero = 1'b1;
                desc.last = 1'b1;
            end
            2'd1: begin
                case (e_reg)
                    3'd0: desc.src = i0;
                    3'd1: begin
                        desc.cut    = 1'b1;
                        desc.corner = 2'd1;
                    end
                    default: begin
                        desc.cut    = 1'b1;
                        desc.sel    = 1'b1;
                        desc.corner = 2'd2;
                        desc.last   = 1'b1;
                    end
                endcase
            end
            2'd2: begin
                case (e_reg)
                    3'd0: desc.src = i0;
                    3'd1: begin
                        desc.src    = i1;
                        desc.corner = 2'd1;
                    end
                    3'd2: begin
                        desc.cut    = 1'b1;
                        desc.corner = 2'd2;
                    end
                    3'd3: begin
                        desc.src     = i1;
                        desc.tri_sel = 1'b1;
                    end
                    3'd4: begin
                        desc.cut     = 1'b1;
                        desc.tri_sel = 1'b1;
                        desc.corner  = 2'd1;
                    end
                    default: begin
                        desc.cut     = 1'b1;
                        desc.sel     = 1'b1;
                        desc.tri_sel = 1'b1;
                        desc.corner  = 2'd2;
                        desc.last    = 1'b1;
                    end
                endcase
            end
            default: begin
                desc.src    = e_reg[1:0];
                desc.corner = e_reg[1:0];
                desc.last   = (e_reg == 3'd2);
            end
        endcase
    end

    // operand selection for the shared unit
    always_comb begin
        fx_op = FXU_SUB;
        fx_a  = vtx_reg[vi_reg][k_reg];
        fx_b  = pnt_reg[k_reg];
        fx_ma = 32'(nrm_reg[k_reg]);
        fx_mb = 32'(tmp_reg);
        case (state_reg)
            ST_D_ACC: begin
                fx_op = FXU_MAC;
                fx_a  = acc_reg;
            end
            ST_V_DEN: begin
                fx_a = dist_reg[ci];
                fx_b = dist_reg[co];
            end
            ST_C_SUB: begin
                fx_a = vtx_reg[co][j_reg];
                fx_b = a_reg;
            end
            ST_C_MUL: fx_ma = 32'($unsigned(t_reg[sel_reg]));
            ST_C_ACC: begin
                fx_op = FXU_MAC;
                fx_a  = a_reg;
            end
            default: fx_op = FXU_SUB;
        endcase
        den_val   = (fx_res < ONE_LSB) ? ONE_LSB : fx_res;
        div_start = (state_reg == ST_V_DEN);
    end

    tpc_fxu #(.W(W), .F(F)) u_fxu (
        .op   (fx_op),
        .a    (fx_a),
        .b    (fx_b),
        .ma   (fx_ma),
        .mb   (fx_mb),
        .p    (prod_reg),
        .res  (fx_res),
        .prod (fx_prod)
    );

    tpc_div #(.W(W), .F(F)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     ($unsigned(dist_reg[ci])),
        .den     ($unsigned(den_val)),
        .status  (div_st),
        .q       (div_q)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_fire && s_vertex_slot == 2'd2) state_next = ST_D_SUB;
            ST_D_SUB: state_next = ST_D_MUL;
            ST_D_MUL: state_next = ST_D_ACC;
            ST_D_ACC: begin
                if (k_reg == 2'd2 && vi_reg == 2'd2) begin
                    state_next = ST_CLASS;
                end else begin
                    state_next = ST_D_SUB;
                end
            end
            ST_CLASS: state_next = (ni == 2'd1 || ni == 2'd2) ? ST_V_DEN : ST_PREP;
            ST_V_DEN: state_next = ST_V_RUN;
            ST_V_RUN: begin
                if (!div_st.busy) begin
                    state_next = sel_reg ? ST_PREP : ST_V_DEN;
                end
            end
            ST_PREP:  state_next = desc.cut ? ST_C_RD : ST_OUT;
            ST_C_RD:  state_next = ST_C_SUB;
            ST_C_SUB: state_next = ST_C_MUL;
            ST_C_MUL: state_next = ST_C_ACC;
            ST_C_ACC: state_next = (j_reg == 3'(NUM_ATTR - 1)) ? ST_OUT : ST_C_RD;
            ST_OUT: begin
                if (out_load) begin
                    state_next = desc.last ? ST_IDLE : ST_PREP;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            held_tag_reg <= '0;
            nrm_reg[0]   <= '0;
            nrm_reg[1]   <= '0;
            nrm_reg[2]   <= sat_word(32'h0001_0000);
            pnt_reg[0]   <= '0;
            pnt_reg[1]   <= '0;
            pnt_reg[2]   <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_NORMAL_X: nrm_reg[0] <= sat_word(cfg_wdata);
                    REG_NORMAL_Y: nrm_reg[1] <= sat_word(cfg_wdata);
                    REG_NORMAL_Z: nrm_reg[2] <= sat_word(cfg_wdata);
                    REG_POINT_X:  pnt_reg[0] <= sat_word(cfg_wdata);
                    REG_POINT_Y:  pnt_reg[1] <= sat_word(cfg_wdata);
                    REG_POINT_Z:  pnt_reg[2] <= sat_word(cfg_wdata);
                    default:      ;
                endcase
            end
            if (s_fire && s_vertex_slot == 2'd0) begin
                held_tag_reg <= s_tri_tag;
            end
        end

        if (s_fire && s_vertex_slot != 2'd3) begin
            vtx_reg[s_vertex_slot][0] <= sat_word(s_pos_x);
            vtx_reg[s_vertex_slot][1] <= sat_word(s_pos_y);
            vtx_reg[s_vertex_slot][2] <= sat_word(s_pos_z);
            vtx_reg[s_vertex_slot][3] <= sat_word(s_tex_u);
            vtx_reg[s_vertex_slot][4] <= sat_word(s_tex_v);
            vtx_reg[s_vertex_slot][5] <= sat_word(s_tex_w);
            vtx_reg[s_vertex_slot][6] <= sat_word(s_light);
        end

        case (state_reg)
            ST_IDLE: begin
                vi_reg  <= '0;
                k_reg   <= '0;
                acc_reg <= '0;
            end
            ST_D_SUB: tmp_reg  <= fx_res;
            ST_D_MUL: prod_reg <= fx_prod;
            ST_D_ACC: begin
                if (k_reg == 2'd2) begin
                    dist_reg[vi_reg] <= fx_res;
                    acc_reg          <= '0;
                    k_reg            <= '0;
                    vi_reg           <= vi_reg + 2'd1;
                end else begin
                    acc_reg <= fx_res;
                    k_reg   <= k_reg + 2'd1;
                end
            end
            ST_CLASS: begin
                sel_reg <= 1'b0;
                e_reg   <= '0;
            end
            ST_V_RUN: begin
                if (!div_st.busy) begin
                    t_reg[sel_reg] <= div_q;
                    sel_reg        <= 1'b1;
                end
            end
            ST_PREP: begin
                j_reg   <= '0;
                sel_reg <= desc.sel;
                for (int a = 0; a < NUM_ATTR; a++) begin
                    wrk_reg[a] <= desc.zero ? '0 : vtx_reg[desc.src][a];
                end
            end
            ST_C_RD:  a_reg    <= vtx_reg[ci][j_reg];
            ST_C_SUB: tmp_reg  <= fx_res;
            ST_C_MUL: prod_reg <= fx_prod;
            ST_C_ACC: begin
                wrk_reg[j_reg] <= fx_res;
                j_reg          <= j_reg + 3'd1;
            end
            ST_OUT: begin
                if (out_load) begin
                    e_reg        <= e_reg + 3'd1;
                    m_out_x      <= 32'(wrk_reg[0]);
                    m_out_y      <= 32'(wrk_reg[1]);
                    m_out_z      <= 32'(wrk_reg[2]);
                    m_out_u      <= 32'(wrk_reg[3]);
                    m_out_v      <= 32'(wrk_reg[4]);
                    m_out_w      <= 32'(wrk_reg[5]);
                    m_out_light  <= 32'(wrk_reg[6]);
                    m_out_tag    <= held_tag_reg;
                    m_out_tri    <= desc.tri_sel;
                    m_out_corner <= desc.corner;
                    m_out_count  <= tri_count;
                    m_out_last   <= desc.last;
                end
            end
            default: ;
        endcase
    end

    a_valid_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("output valid raised outside the emit step");

    a_div_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.busy |-> state_reg == ST_V_RUN)
        else $error("divider busy outside the division wait");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_out_count == 2'd0 |-> m_out_last)
        else $error("fully clipped transaction not marked last");

    a_emit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT && m_valid_reg && !m_ready |=> state_reg == ST_OUT)
        else $error("emit step left while output stalled");

endmodule
